>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, held off while reset is asserted (active-low reset).
`define PFC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");
// Clocked check that also holds during reset.
`define PFC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define PFC_ASSERT(lbl, clk, rstn, prop)
`define PFC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/pfc_pkg.sv
// Shared types and constants for the Pareto fitness compare unit.
package pfc_pkg;

    localparam int OBJ_SLOTS   = 4;   // objective slots per vector in a transaction
    localparam int CFG_W       = 3;
    localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;
    localparam int RESULT_W    = 17;
    localparam int OUT_TDATA_W = 40;

    // per-lane comparison of one objective
    typedef struct packed {
        logic le;
        logic lt;
        logic eq;
    } pfc_cmp_t;

    // merged verdict over all active lanes
    typedef struct packed {
        logic dominates;
        logic equal;
    } pfc_verdict_t;

endpackage

>>> rtl/pfc_lane.sv
// One objective lane: compare, magnitudes, then squares.
module pfc_lane #(
    parameter int OBJ_W = 16
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic                    active,
    input  logic [OBJ_W-1:0]        a,
    input  logic [OBJ_W-1:0]        b,
    output pfc_pkg::pfc_cmp_t       cmp,
    output logic [2*OBJ_W+1:0]      dist_sq,
    output logic [2*OBJ_W+1:0]      norm_sq
);
    localparam int SQ_W = 2 * OBJ_W + 2;

    logic [OBJ_W:0]       diff;
    logic [OBJ_W:0]       dmag;
    logic [OBJ_W-1:0]     amag;
    pfc_pkg::pfc_cmp_t    cmp_next;

    pfc_pkg::pfc_cmp_t    cmp_a_reg;
    logic [OBJ_W:0]       dmag_reg;
    logic [OBJ_W-1:0]     amag_reg;

    logic [SQ_W-1:0]      dprod;
    logic [2*OBJ_W-1:0]   aprod;
    pfc_pkg::pfc_cmp_t    cmp_reg;
    logic [SQ_W-1:0]      dist_sq_reg;
    logic [SQ_W-1:0]      norm_sq_reg;

    assign diff = {a[OBJ_W-1], a} - {b[OBJ_W-1], b};
    assign dmag = diff[OBJ_W] ? (~diff + 1'b1) : diff;
    assign amag = a[OBJ_W-1] ? (~a + 1'b1) : a;

    always_comb begin
        // an inactive lane is neutral for every reduction
        cmp_next.le = 1'b1;
        cmp_next.lt = 1'b0;
        cmp_next.eq = 1'b1;
        if (active) begin
            cmp_next.le = ($signed(a) <= $signed(b));
            cmp_next.lt = ($signed(a) <  $signed(b));
            cmp_next.eq = (a == b);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmp_a_reg <= cmp_next;
            dmag_reg  <= active ? dmag : '0;
            amag_reg  <= active ? amag : '0;
        end
    end

    assign dprod = dmag_reg * dmag_reg;
    assign aprod = amag_reg * amag_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cmp_reg     <= cmp_a_reg;
            dist_sq_reg <= dprod;
            norm_sq_reg <= SQ_W'(aprod);
        end
    end

    assign cmp     = cmp_reg;
    assign dist_sq = dist_sq_reg;
    assign norm_sq = norm_sq_reg;

endmodule

>>> rtl/pfc_merge.sv
// Merges lane results: dominance/equality verdict and sums of squares.
module pfc_merge #(
    parameter int LANES = 4,
    parameter int SQ_W  = 34
) (
    input  logic                    aclk,
    input  logic                    en,
    input  pfc_pkg::pfc_cmp_t       cmp     [LANES],
    input  logic [SQ_W-1:0]         dist_sq [LANES],
    input  logic [SQ_W-1:0]         norm_sq [LANES],
    output pfc_pkg::pfc_verdict_t   verdict,
    output logic [SQ_W+1:0]         dist_sum,
    output logic [SQ_W+1:0]         norm_sum
);
    localparam int SUM_W = SQ_W + 2;

    pfc_pkg::pfc_verdict_t verdict_next;
    logic [SUM_W-1:0]      dist_next;
    logic [SUM_W-1:0]      norm_next;

    pfc_pkg::pfc_verdict_t verdict_reg;
    logic [SUM_W-1:0]      dist_sum_reg;
    logic [SUM_W-1:0]      norm_sum_reg;

    always_comb begin
        logic all_le;
        logic any_lt;
        logic all_eq;
        all_le    = 1'b1;
        any_lt    = 1'b0;
        all_eq    = 1'b1;
        dist_next = '0;
        norm_next = '0;
        for (int i = 0; i < LANES; i++) begin
            all_le    = all_le & cmp[i].le;
            any_lt    = any_lt | cmp[i].lt;
            all_eq    = all_eq & cmp[i].eq;
            dist_next = dist_next + SUM_W'(dist_sq[i]);
            norm_next = norm_next + SUM_W'(norm_sq[i]);
        end
        verdict_next.dominates = all_le & any_lt;
        verdict_next.equal     = all_eq;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            verdict_reg  <= verdict_next;
            dist_sum_reg <= dist_next;
            norm_sum_reg <= norm_next;
        end
    end

    assign verdict  = verdict_reg;
    assign dist_sum = dist_sum_reg;
    assign norm_sum = norm_sum_reg;

endmodule

>>> rtl/pfc_isqrt.sv
// Pipelined floor square root, one root bit per stage.
module pfc_isqrt #(
    parameter int IN_W = 36
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [IN_W-1:0]           radicand,
    output logic [(IN_W+1)/2-1:0]     root
);
    localparam int ROOT_W  = (IN_W + 1) / 2;
    localparam int TRIAL_W = 2 * ROOT_W + 1;

    logic [IN_W-1:0]   rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [IN_W-1:0]   rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int J = ROOT_W - 1 - k;
        logic [IN_W-1:0]    rem_cur;
        logic [ROOT_W-1:0]  root_cur;
        logic [TRIAL_W-1:0] trial;
        logic               fits;

        if (k == 0) begin : g_first
            assign rem_cur  = radicand;
            assign root_cur = '0;
        end else begin : g_next
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
        end

        // (r + 2^J)^2 - r^2 = r*2^(J+1) + 2^(2J)
        assign trial = (TRIAL_W'(root_cur) << (J + 1)) + (TRIAL_W'(1) << (2 * J));
        assign fits  = (TRIAL_W'(rem_cur) >= trial);
        assign rem_next[k]  = fits ? IN_W'(TRIAL_W'(rem_cur) - trial) : rem_cur;
        assign root_next[k] = fits ? (root_cur | (ROOT_W'(1) << J)) : root_cur;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

>>> rtl/pareto_fitness_compare_unit.sv
// Pareto dominance, equality, distance and norm of two objective vectors.
//
//  Channel  Dir  Handshake             Payload
//  s_       in   s_tvalid/s_tready     s_tdata: A objectives 0..3, B objectives 0..3
//  m_       out  m_tvalid/m_tready     m_tdata: dominates, equal, distance, norm_a
//  cfg_     in   cfg_valid/cfg_ready   cfg_data: active_objectives
//
// Throughput: one transaction per cycle while the skid register is empty. A
// result passes two lane stages, the merge stage, ROOT_W root stages and the
// output register on its way to m_tvalid; ROOT_W = OBJ_WIDTH + 2.
// The root pipeline produces one result bit per stage and sets the depth.
// aresetn is synchronous, active low; it clears the pipeline, output and skid
// valid bits (not the data registers) and sets active_objectives to 4.
// When m_tready is low the output register holds and one more result lands in
// the skid register; s_tready (a register) then drops and the pipeline freezes.
`include "assert_macros.svh"

module pareto_fitness_compare_unit #(
    parameter int MAX_OBJECTIVES = 4,
    parameter int OBJ_WIDTH      = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // a_obj0..a_obj3, b_obj0..b_obj3, OBJ_WIDTH bits each, from bit 0 up
    input  logic [2*pfc_pkg::OBJ_SLOTS*OBJ_WIDTH-1:0] s_tdata,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // a_dominates, vectors_equal, distance[16:0], norm_a[16:0], 4 zero bits
    output logic [pfc_pkg::OUT_TDATA_W-1:0]           m_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    input  logic [pfc_pkg::CFG_W-1:0]                 cfg_data,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready
);
    localparam int SQ_W    = 2 * OBJ_WIDTH + 2;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = (SUM_W + 1) / 2;
    localparam int PIPE_D  = 3 + ROOT_W;
    localparam int SLOTS   = pfc_pkg::OBJ_SLOTS;
    localparam int RES_W   = pfc_pkg::RESULT_W;
    localparam int OUT_W   = pfc_pkg::OUT_TDATA_W;
    localparam int PAD_W   = OUT_W - 2 - 2 * RES_W;

    // ---------------- configuration ----------------
    logic [pfc_pkg::CFG_W-1:0] objectives_reg;
    logic [pfc_pkg::CFG_W-1:0] objectives_next;
    logic [pfc_pkg::CFG_W-1:0] n_eff;

    assign cfg_ready = 1'b1;

    always_comb begin
        objectives_next = objectives_reg;
        if (cfg_valid && cfg_ready) begin
            objectives_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            objectives_reg <= pfc_pkg::CFG_RESET;
        end else begin
            objectives_reg <= objectives_next;
        end
    end

    // zero counts as one lane, anything above the lane count saturates
    always_comb begin
        n_eff = objectives_reg;
        if (objectives_reg == '0) begin
            n_eff = pfc_pkg::CFG_W'(1);
        end else if (objectives_reg > pfc_pkg::CFG_W'(MAX_OBJECTIVES)) begin
            n_eff = pfc_pkg::CFG_W'(MAX_OBJECTIVES);
        end
    end

    // ---------------- pipeline control ----------------
    logic              en;
    logic [PIPE_D-1:0] valid_reg;
    logic              skid_valid_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  skid_data_reg;
    logic [OUT_W-1:0]  out_data_reg;

    // whole pipeline advances unless the skid stage is occupied
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[PIPE_D-2:0], s_tvalid};
        end
    end

    // ---------------- lanes ----------------
    pfc_pkg::pfc_cmp_t lane_cmp  [MAX_OBJECTIVES];
    logic [SQ_W-1:0]   lane_dist [MAX_OBJECTIVES];
    logic [SQ_W-1:0]   lane_norm [MAX_OBJECTIVES];

    for (genvar i = 0; i < MAX_OBJECTIVES; i++) begin : g_lane
        pfc_lane #(
            .OBJ_W   (OBJ_WIDTH)
        ) u_lane (
            .aclk    (aclk),
            .en      (en),
            .active  (pfc_pkg::CFG_W'(i) < n_eff),
            .a       (s_tdata[i*OBJ_WIDTH +: OBJ_WIDTH]),
            .b       (s_tdata[(SLOTS+i)*OBJ_WIDTH +: OBJ_WIDTH]),
            .cmp     (lane_cmp[i]),
            .dist_sq (lane_dist[i]),
            .norm_sq (lane_norm[i])
        );
    end

    // ---------------- merge ----------------
    pfc_pkg::pfc_verdict_t merged;
    logic [SUM_W-1:0]      dist_sum;
    logic [SUM_W-1:0]      norm_sum;

    pfc_merge #(
        .LANES    (MAX_OBJECTIVES),
        .SQ_W     (SQ_W)
    ) u_merge (
        .aclk     (aclk),
        .en       (en),
        .cmp      (lane_cmp),
        .dist_sq  (lane_dist),
        .norm_sq  (lane_norm),
        .verdict  (merged),
        .dist_sum (dist_sum),
        .norm_sum (norm_sum)
    );

    // ---------------- square roots ----------------
    logic [ROOT_W-1:0] dist_root;
    logic [ROOT_W-1:0] norm_root;

    pfc_isqrt #(
        .IN_W     (SUM_W)
    ) u_dist_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (dist_sum),
        .root     (dist_root)
    );

    pfc_isqrt #(
        .IN_W     (SUM_W)
    ) u_norm_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (norm_sum),
        .root     (norm_root)
    );

    // verdict rides alongside the root pipeline
    pfc_pkg::pfc_verdict_t verdict_reg [ROOT_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            verdict_reg[0] <= merged;
            for (int k = 1; k < ROOT_W; k++) begin
                verdict_reg[k] <= verdict_reg[k-1];
            end
        end
    end

    // ---------------- output register + skid ----------------
    logic [OUT_W-1:0] pipe_data;
    logic             pipe_push;

    assign pipe_data = {{PAD_W{1'b0}},
                        RES_W'(norm_root),
                        RES_W'(dist_root),
                        verdict_reg[ROOT_W-1].equal,
                        verdict_reg[ROOT_W-1].dominates};
    assign pipe_push = en && valid_reg[PIPE_D-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= pipe_push;
            end
        end else if (pipe_push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : pipe_data;
        end else if (pipe_push) begin
            skid_data_reg <= pipe_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- checks ----------------
    // equal vectors can never dominate each other
    `PFC_ASSERT(a_dom_excl_eq, aclk, aresetn, m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    // identical vectors give zero distance through the whole root pipeline
    `PFC_ASSERT(a_eq_zero_dist, aclk, aresetn, (m_tvalid && m_tdata[1]) |-> (m_tdata[2 +: RES_W] == '0))
    // skid only fills behind a stalled, full output register
    `PFC_ASSERT(a_skid_fill, aclk, aresetn, $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
    // skid never holds data while the output register is empty
    `PFC_ASSERT(a_skid_order, aclk, aresetn, skid_valid_reg |-> out_valid_reg)

endmodule

>>> tb/sv/pareto_verdict_check.sv
`timescale 1ns / 1ps
// Monitor that predicts and checks each result of the Pareto fitness compare unit.
module pareto_verdict_check #(
    parameter int OBJ_W = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic [2*pfc_pkg::OBJ_SLOTS*OBJ_W-1:0]   s_tdata,
    input  logic                                    s_tvalid,
    input  logic                                    s_tready,
    input  logic [pfc_pkg::OUT_TDATA_W-1:0]         m_tdata,
    input  logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic [pfc_pkg::CFG_W-1:0]               cfg_data,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    output int                                      fail_count,
    output int                                      pending
);

    // s_tdata: a_obj0..a_obj3, b_obj0..b_obj3 from bit 0 up
    typedef struct packed {
        logic [pfc_pkg::OBJ_SLOTS-1:0][OBJ_W-1:0] b;
        logic [pfc_pkg::OBJ_SLOTS-1:0][OBJ_W-1:0] a;
    } obj_pair_t;

    // m_tdata: a_dominates, vectors_equal, distance, norm_a, zero pad from bit 0 up
    typedef struct packed {
        logic [pfc_pkg::OUT_TDATA_W-2*pfc_pkg::RESULT_W-3:0] pad;
        logic [pfc_pkg::RESULT_W-1:0]                        norm_a;
        logic [pfc_pkg::RESULT_W-1:0]                        distance;
        logic                                                vectors_equal;
        logic                                                a_dominates;
    } fit_result_t;

    logic [pfc_pkg::CFG_W-1:0] active_cfg;
    fit_result_t               verdict_q[$];
    fit_result_t               want;
    fit_result_t               got;

    // floor square root, one result bit per step from the top
    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int k = 31; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic fit_result_t predict_fitness(obj_pair_t p,
                                                    logic [pfc_pkg::CFG_W-1:0] n_cfg);
        fit_result_t r;
        int          n;
        logic        no_worse;
        logic        some_better;
        logic        same;
        longint      ai;
        longint      bi;
        longint      diff;
        logic [63:0] dist_sq;
        logic [63:0] norm_sq;
        logic [63:0] root;
        n = n_cfg;
        if (n < 1)
            n = 1;
        if (n > pfc_pkg::OBJ_SLOTS)
            n = pfc_pkg::OBJ_SLOTS;
        no_worse    = 1'b1;
        some_better = 1'b0;
        same        = 1'b1;
        dist_sq     = '0;
        norm_sq     = '0;
        for (int i = 0; i < n; i++) begin
            ai = $signed(p.a[i]);
            bi = $signed(p.b[i]);
            if (ai > bi)
                no_worse = 1'b0;
            if (ai < bi)
                some_better = 1'b1;
            if (ai != bi)
                same = 1'b0;
            diff    = ai - bi;
            dist_sq = dist_sq + diff * diff;
            norm_sq = norm_sq + ai * ai;
        end
        r               = '0;
        r.a_dominates   = no_worse && some_better;
        r.vectors_equal = same;
        root            = floor_root(dist_sq);
        r.distance      = root[pfc_pkg::RESULT_W-1:0];
        root            = floor_root(norm_sq);
        r.norm_a        = root[pfc_pkg::RESULT_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(string what, fit_result_t w, fit_result_t g);
        fail_count++;
        if (fail_count <= 10)
            $display({"%0t %s: expected dom=%0b eq=%0b dist=%0d norm=%0d pad=%0h,",
                      " got dom=%0b eq=%0b dist=%0d norm=%0d pad=%0h"},
                     $time, what, w.a_dominates, w.vectors_equal, w.distance, w.norm_a,
                     w.pad, g.a_dominates, g.vectors_equal, g.distance, g.norm_a, g.pad);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            active_cfg = pfc_pkg::CFG_RESET;
            verdict_q.delete();
        end else begin
            // an input and a register write never meet at one edge; input first anyway
            if (s_tvalid && s_tready)
                verdict_q.insert(verdict_q.size(),
                                 predict_fitness(obj_pair_t'(s_tdata), active_cfg));
            if (cfg_valid && cfg_ready)
                active_cfg = cfg_data;
            if (m_tvalid && m_tready) begin
                got = fit_result_t'(m_tdata);
                if (verdict_q.size() == 0) begin
                    note_mismatch("result with nothing outstanding", '0, got);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.a_dominates !== want.a_dominates
                        || got.vectors_equal !== want.vectors_equal
                        || got.distance !== want.distance
                        || got.norm_a !== want.norm_a
                        || got.pad !== want.pad)
                        note_mismatch("result mismatch", want, got);
                end
            end
        end
        pending = verdict_q.size();
    end

endmodule

>>> tb/sv/pareto_fitness_compare_unit_tb.sv
`timescale 1ns / 1ps
// Top of the Pareto fitness compare testbench: clock, reset, stimulus and verdict.
module pareto_fitness_compare_unit_tb;

    localparam int OBJ_W        = 16;
    localparam int PAIR_W       = 2 * pfc_pkg::OBJ_SLOTS * OBJ_W;
    localparam int PIPE_LATENCY = 22;    // pipeline depth from input to m_tvalid
    localparam int HOLD_CYCLES  = 120;   // long m_tready hold-off, fills the pipe
    localparam int HOLD_ITEMS   = 60;    // items offered back to back during the hold
    localparam int PHASE_ITEMS  = 65;
    // Longest correct stretch without any transaction is the long hold-off
    // (HOLD_CYCLES) plus a short stall burst.
    localparam int QUIET_LIMIT  = 2000;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    // a_obj0..a_obj3, b_obj0..b_obj3, 16 bits each, from bit 0 up
    logic [PAIR_W-1:0]                s_tdata   = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    // a_dominates, vectors_equal, distance[16:0], norm_a[16:0], 4 zero bits
    logic [pfc_pkg::OUT_TDATA_W-1:0]  m_tdata;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [pfc_pkg::CFG_W-1:0]        cfg_data  = '0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;

    int fail_count;
    int pending;

    // receiver control: rx_idle enables stall bursts, a toggle of hold_req
    // asks for one long hold-off
    logic rx_idle  = 1'b0;
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left;
    int   stall_left;
    int   quiet_cycles;

    // sender side idling, private to the stimulus process
    bit   tx_idle;

    always #2 aclk = ~aclk;

    pareto_fitness_compare_unit #(
        .MAX_OBJECTIVES (4),
        .OBJ_WIDTH      (OBJ_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    pareto_verdict_check #(
        .OBJ_W (OBJ_W)
    ) verdict_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_data   (cfg_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result side: m_tready gets exactly one assignment per edge. A long hold
    // wins over the short random bursts.
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (aresetn && rx_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: cycles in a row with no transaction on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic logic [3:0][15:0] vec4(logic [15:0] o0, logic [15:0] o1,
                                              logic [15:0] o2, logic [15:0] o3);
        return {o3, o2, o1, o0};
    endfunction

    // Offer one vector pair and hold it until the transaction; valid stays
    // high into the next call unless a sender gap is drawn.
    task automatic send_pair(input logic [3:0][15:0] av, input logic [3:0][15:0] bv);
        s_tdata  <= {bv, av};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every predicted result has come back.
    // It first lets the monitor count the last input.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    // Register write, only with the pipe empty (every item yields a result).
    task automatic write_active_objectives(input logic [pfc_pkg::CFG_W-1:0] v);
        drain_results();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_obj();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4, 5:    return 16'($signed($urandom_range(0, 511)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // Pair shapes: mostly ones that exercise dominance and equality,
    // with independent full-range pairs as the remainder.
    task automatic make_pair(output logic [3:0][15:0] av, output logic [3:0][15:0] bv);
        int shape;
        int lane;
        shape = $urandom_range(0, 9);
        for (int i = 0; i < pfc_pkg::OBJ_SLOTS; i++) begin
            av[i] = rand_obj();
            bv[i] = rand_obj();
        end
        case (shape)
            3, 4: begin   // A no worse than B, often strictly better
                for (int i = 0; i < pfc_pkg::OBJ_SLOTS; i++)
                    bv[i] = av[i] + 16'($urandom_range(0, 1) * $urandom_range(0, 3));
            end
            5: begin      // B no worse than A
                for (int i = 0; i < pfc_pkg::OBJ_SLOTS; i++)
                    av[i] = bv[i] + 16'($urandom_range(0, 1) * $urandom_range(0, 3));
            end
            6: bv = av;
            7: begin      // equal but for one lane
                lane     = $urandom_range(0, pfc_pkg::OBJ_SLOTS - 1);
                bv       = av;
                bv[lane] = rand_obj();
            end
            8, 9: begin   // tiny values: lanes land on lt, eq and gt in a mix
                for (int i = 0; i < pfc_pkg::OBJ_SLOTS; i++) begin
                    av[i] = 16'($signed($urandom_range(0, 6)) - 3);
                    bv[i] = 16'($signed($urandom_range(0, 6)) - 3);
                end
            end
            default: ;
        endcase
    endtask

    // Lane 0 decides alone when one objective is active: equal there with
    // the rest different, then better there with the rest worse.
    task automatic send_lane0_probes();
        send_pair(vec4(16'h0100, 16'h8000, 16'h7FFF, 16'h0000),
                  vec4(16'h0100, 16'h7FFF, 16'h8000, 16'h0001));
        send_pair(vec4(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF),
                  vec4(16'h7FFF, 16'h8000, 16'h8000, 16'h8000));
    endtask

    initial begin
        logic [3:0][15:0]          av;
        logic [3:0][15:0]          bv;
        logic [pfc_pkg::CFG_W-1:0] phase_cfg[9];
        bit                        phase_idle[9];

        // reset value of active_objectives (4) comes first, then the phases take 2, 3,
        // 5, 4, 6, 1, 0, 7 and go back to full width
        phase_cfg  = '{3'd2, 3'd3, 3'd5, 3'd4, 3'd6, 3'd1, 3'd0, 3'd7, 3'd4};
        phase_idle = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
        tx_idle    = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, full four objectives from reset
        send_pair(vec4(16'h0000, 16'h0000, 16'h0000, 16'h0000),
                  vec4(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        // B dominates, largest distance
        send_pair(vec4(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
                  vec4(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        // A dominates, largest norm
        send_pair(vec4(16'h8000, 16'h8000, 16'h8000, 16'h8000),
                  vec4(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        // strictly better in one lane only
        send_pair(vec4(16'h0100, 16'h0200, 16'h0300, 16'h0400),
                  vec4(16'h0100, 16'h0200, 16'h0300, 16'h0401));
        // trade-off: neither dominates
        send_pair(vec4(16'h0100, 16'h0500, 16'h0000, 16'h0000),
                  vec4(16'h0200, 16'h0400, 16'h0000, 16'h0000));
        // equal, nonzero
        send_pair(vec4(16'hFF80, 16'h0080, 16'h1234, 16'hEDCB),
                  vec4(16'hFF80, 16'h0080, 16'h1234, 16'hEDCB));
        // one LSB below everywhere
        send_pair(vec4(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                  vec4(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        // alternating extremes
        send_pair(vec4(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF),
                  vec4(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));

        // one objective, zero treated as one, seven saturated to four
        write_active_objectives(3'd1);
        send_lane0_probes();
        write_active_objectives(3'd0);
        send_lane0_probes();
        write_active_objectives(3'd7);
        send_lane0_probes();

        // random phases, one register setting each
        for (int p = 0; p < 9; p++) begin
            write_active_objectives(phase_cfg[p]);
            rx_idle <= phase_idle[p];
            tx_idle  = 1'b0;
            if (p == 2) begin
                // long receiver hold while pairs keep coming back to back:
                // the pipe and skid fill and s_tready has to drop
                hold_req <= ~hold_req;
                for (int k = 0; k < HOLD_ITEMS; k++) begin
                    make_pair(av, bv);
                    send_pair(av, bv);
                end
            end
            tx_idle = phase_idle[p];
            for (int k = (p == 2) ? HOLD_ITEMS : 0; k < PHASE_ITEMS; k++) begin
                make_pair(av, bv);
                send_pair(av, bv);
            end
        end

        drain_results();
        repeat (PIPE_LATENCY + 8) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
